/* src/c3lb_pkg.sv */
`default_nettype none

package c3lb_pkg;

	localparam int KSIZE         = 3;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int COEF_FRAC_BITS = 8;

	localparam int PIX_W      = 8;
	localparam int TAP_W      = 16;
	localparam int PROD_W     = 25;   // signed 16 x unsigned 8
	localparam int CSUM_W     = 27;   // three products
	localparam int ACC_W      = 29;   // three column sums
	localparam int ROW_W      = 16;
	localparam int OUT_CNT_W  = 26;
	localparam int FW_W       = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [63:0]         TAPS_LO_RST = 64'd0;
	localparam logic [63:0]         TAPS_HI_RST = 64'd256;
	localparam logic [TAP_W-1:0]    TAP8_RST    = 16'd0;
	localparam logic [FW_W-1:0]     WIDTH_RST   = 11'd1024;
	localparam logic [ROW_W-1:0]    HEIGHT_RST  = 16'd480;

	typedef logic [PIX_W-1:0]            pix_t;
	typedef pix_t [KSIZE-1:0]            col_t;    // index 0 is the top row
	typedef logic signed [TAP_W-1:0]     tap_t;
	typedef tap_t [KSIZE-1:0]            tap_col_t;
	typedef logic signed [CSUM_W-1:0]    csum_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAPS_LO = 3'd0,
		REG_TAPS_HI = 3'd1,
		REG_TAP8    = 3'd2,
		REG_WIDTH   = 3'd3,
		REG_HEIGHT  = 3'd4,
		REG_MODE    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic take;    // store load_in into the window column
		logic clear;   // frame end: window back to zero
		logic adv1;
		logic adv2;
		logic adv3;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* src/conv3x3_line_buffered_core.sv */
`default_nettype none

// 3x3 convolution over one 8-bit image plane, streamed in raster order.
//
// Input channel (in_valid / in_stall): one request per sample, cmd 0 for a
// pixel, cmd 1 for a drain request that feeds zero padding. After the last
// pixel of a frame send frame_width + 1 drain requests to flush it.
// Output channel (out_valid / out_stall): one request per filtered pixel,
// out_last marks the final pixel of the frame. The result for frame position
// q is produced by the input request at stream position q + frame_width + 1.
// Config channel (cfg_valid / cfg_ready): always ready; write only while idle.
//
// Throughput: one request per clock while in_stall is low, set by the
// single-port-per-cycle line stores (one read and one write each cycle) and
// the three column cells. A result passes through the registered stages
// window, products, column sums, total and output, in that order.
// When the receiver stalls, the pipeline fills its empty stages first, then
// in_stall rises; nothing is dropped. Reset clears counters, window, valid
// bits and configuration registers; the line stores need no clearing since
// rows are always written before they are read.
module conv3x3_line_buffered_core #(
	parameter int MAX_WIDTH = c3lb_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input requests
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              cmd,
	input  wire logic [c3lb_pkg::PIX_W-1:0]        in_sample,
	// output requests
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [c3lb_pkg::PIX_W-1:0]        out_pixel,
	output logic                                   out_last,
	// register writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [c3lb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [c3lb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import c3lb_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int WCW    = (WW > FW_W) ? WW : FW_W;
	localparam int AREA_W = WCW + ROW_W;
	localparam logic [WCW-1:0]          MW_C      = WCW'(MAX_WIDTH);
	localparam logic signed [ACC_W-1:0] FRAC_MASK = ACC_W'((1 << COEF_FRAC_BITS) - 1);

	// ---------------- configuration registers ----------------
	logic [63:0]       taps_lo_q, taps_hi_q;
	logic [TAP_W-1:0]  tap8_q;
	logic [FW_W-1:0]   fw_q;
	logic [ROW_W-1:0]  fh_q;
	logic              mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_lo_q <= TAPS_LO_RST;
			taps_hi_q <= TAPS_HI_RST;
			tap8_q    <= TAP8_RST;
			fw_q      <= WIDTH_RST;
			fh_q      <= HEIGHT_RST;
			mode_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TAPS_LO: taps_lo_q <= cfg_data;
				REG_TAPS_HI: taps_hi_q <= cfg_data;
				REG_TAP8:    tap8_q    <= cfg_data[TAP_W-1:0];
				REG_WIDTH:   fw_q      <= cfg_data[FW_W-1:0];
				REG_HEIGHT:  fh_q      <= cfg_data[ROW_W-1:0];
				REG_MODE:    mode_q    <= cfg_data[0];
				default: ;   // unknown index, dropped
			endcase
		end
	end

	// effective frame size: width clamped to 1..MAX_WIDTH, height at least 1
	logic [WCW-1:0]    fw_ext, w_eff;
	logic [ROW_W-1:0]  h_eff;

	assign fw_ext = WCW'(fw_q);

	always_comb begin
		if (fw_q == '0) begin
			w_eff = WCW'(1);
		end else if (fw_ext > MW_C) begin
			w_eff = MW_C;
		end else begin
			w_eff = fw_ext;
		end
		h_eff = (fh_q == '0) ? ROW_W'(1) : fh_q;
	end

	// frame area, re-registered every cycle; first needed when the first result
	// of a frame is counted, long after any write settles
	logic [AREA_W-1:0] area_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
		end else begin
			area_q <= AREA_W'(w_eff) * AREA_W'(h_eff);
		end
	end

	// taps, row-major
	tap_t     all_taps [KSIZE*KSIZE];
	tap_col_t cell_taps [KSIZE];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			all_taps[k]     = tap_t'(taps_lo_q[16*k +: 16]);
			all_taps[k + 4] = tap_t'(taps_hi_q[16*k +: 16]);
		end
		all_taps[8] = tap_t'(tap8_q);
	end

	// ---------------- pipeline handshake ----------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic accept;

	assign rdy5     = !out_valid || !out_stall;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign accept   = in_valid && rdy1;

	// ---------------- position counters ----------------
	logic [CW-1:0]        col_q;
	logic [ROW_W-1:0]     row_q;
	logic [OUT_CNT_W-1:0] out_cnt_q;

	logic [WCW-1:0]       x_plus;
	logic                 row_end;
	logic                 emit, last_c;
	logic [OUT_CNT_W-1:0] out_next;
	logic [CW-1:0]        col_nxt;

	assign x_plus   = WCW'(col_q) + WCW'(1);
	assign row_end  = (x_plus >= w_eff);
	// first result once the window centre reaches row 0, column 0
	assign emit     = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
	assign out_next = out_cnt_q + OUT_CNT_W'(1);
	assign last_c   = emit && (AREA_W'(out_next) >= area_q);

	always_comb begin
		if (last_c || row_end) begin
			col_nxt = '0;
		end else begin
			col_nxt = x_plus[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			out_cnt_q <= '0;
		end else if (accept) begin
			col_q <= col_nxt;
			if (last_c) begin
				row_q     <= '0;
				out_cnt_q <= '0;
			end else begin
				if (emit) begin
					out_cnt_q <= out_next;
				end
				if (row_end && row_q != '1) begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end
	end

	// ---------------- line stores ----------------
	// upper store: row two above; lower store: row above.
	// The read address runs one request ahead so the data is ready when the
	// request shows up; same-address read and write is bypassed.
	logic [CW-1:0]    raddr;
	pix_t             up_rd, lo_rd;
	pix_t             byp_up_q, byp_lo_q;
	logic             byp_q;
	pix_t             s_pix, a_pix, b_pix;

	assign raddr = accept ? col_nxt : col_q;

	assign s_pix = (!cmd && row_q < h_eff) ? in_sample : '0;
	assign a_pix = (row_q >= ROW_W'(2)) ? (byp_q ? byp_up_q : up_rd) : '0;
	assign b_pix = (row_q >= ROW_W'(1)) ? (byp_q ? byp_lo_q : lo_rd) : '0;

	c3lb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_up (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (b_pix),
		.raddr (raddr),
		.rdata (up_rd)
	);

	c3lb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_lo (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (s_pix),
		.raddr (raddr),
		.rdata (lo_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= accept && (raddr == col_q);
		end
	end

	always_ff @(posedge clk) begin
		byp_up_q <= b_pix;
		byp_lo_q <= s_pix;
	end

	// ---------------- window cells ----------------
	// Each cell holds one window column and shifts left into its neighbor.
	// At column 0 the result of the previous row's last pixel is taken with
	// a zero column on the right (right padding); the stored window then
	// becomes [old right column, zero, new column] (left padding next).
	col_t      new_col, in_cmp_col;
	col_t      cell_col  [KSIZE];
	col_t      cell_load [KSIZE];
	csum_t     cell_sum  [KSIZE];
	cell_ctl_t ctl;
	logic      first_col;

	assign new_col    = {s_pix, b_pix, a_pix};
	assign first_col  = (col_q == '0);
	assign in_cmp_col = first_col ? '0 : new_col;

	assign ctl.take  = accept;
	assign ctl.clear = accept && last_c;
	assign ctl.adv1  = rdy1;
	assign ctl.adv2  = rdy2;
	assign ctl.adv3  = rdy3;

	for (genvar c = 0; c < KSIZE; c++) begin : g_cell
		col_t shift_c;

		if (c == KSIZE - 1) begin : g_edge
			assign shift_c      = in_cmp_col;
			assign cell_load[c] = new_col;
		end else if (c == KSIZE - 2) begin : g_gap
			assign shift_c      = cell_col[c+1];
			assign cell_load[c] = first_col ? '0 : cell_col[c+1];
		end else begin : g_body
			assign shift_c      = cell_col[c+1];
			assign cell_load[c] = first_col ? cell_col[c+2] : cell_col[c+1];
		end

		for (genvar r = 0; r < KSIZE; r++) begin : g_tap
			assign cell_taps[c][r] = all_taps[r*KSIZE + c];
		end

		c3lb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.shift_in (shift_c),
			.load_in  (cell_load[c]),
			.taps     (cell_taps[c]),
			.col      (cell_col[c]),
			.csum     (cell_sum[c])
		);
	end

	// ---------------- valid / last tracking ----------------
	logic last_s1, last_s2, last_s3, last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= accept && emit;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) last_s1 <= last_c;
		if (rdy2) last_s2 <= last_s1;
		if (rdy3) last_s3 <= last_s2;
		if (rdy4) last_s4 <= last_s3;
	end

	// ---------------- total, truncation, output ----------------
	logic signed [ACC_W-1:0] acc_c, acc_s4, tq;
	pix_t                    pix_c;

	always_comb begin
		acc_c = '0;
		for (int c = 0; c < KSIZE; c++) begin
			acc_c = acc_c + ACC_W'(cell_sum[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) acc_s4 <= acc_c;
	end

	// divide by 2^frac, rounding toward zero
	always_comb begin
		if (acc_s4[ACC_W-1]) begin
			tq = (acc_s4 + FRAC_MASK) >>> COEF_FRAC_BITS;
		end else begin
			tq = acc_s4 >>> COEF_FRAC_BITS;
		end
		if (!mode_q) begin
			pix_c = tq[PIX_W-1:0];
		end else if (tq[ACC_W-1]) begin
			pix_c = '0;
		end else if (tq > ACC_W'(255)) begin
			pix_c = '1;
		end else begin
			pix_c = tq[PIX_W-1:0];
		end
	end

	logic out_valid_q, out_last_q;
	pix_t out_pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy5) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			out_pixel_q <= pix_c;
			out_last_q  <= last_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;

	// ---------------- assertions ----------------
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output stage");

	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_c) |=> (col_q == '0 && row_q == '0 && out_cnt_q == '0))
		else $error("counters not cleared after frame end");

	a_s1_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> (!v_s1 || $past(v_s1)))
		else $error("window stage filled without an input request");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(out_pixel) && $stable(out_last)))
		else $error("stalled output request changed");

endmodule

`default_nettype wire

/* src/c3lb_ram.sv */
`default_nettype none

module c3lb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/c3lb_cell.sv */
`default_nettype none

module c3lb_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire c3lb_pkg::cell_ctl_t  ctl,
	input  wire c3lb_pkg::col_t       shift_in,
	input  wire c3lb_pkg::col_t       load_in,
	input  wire c3lb_pkg::tap_col_t   taps,
	output c3lb_pkg::col_t            col,
	output c3lb_pkg::csum_t           csum
);
	import c3lb_pkg::*;

	col_t                      col_q;
	col_t                      cmp_s1;
	logic signed [PROD_W-1:0]  prod_s2 [KSIZE];
	csum_t                     sum_s3;
	csum_t                     sum_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.clear) begin
			col_q <= '0;
		end else if (ctl.take) begin
			col_q <= load_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			cmp_s1 <= shift_in;
		end
		if (ctl.adv2) begin
			for (int i = 0; i < KSIZE; i++) begin
				prod_s2[i] <= $signed(taps[i]) * $signed({1'b0, cmp_s1[i]});
			end
		end
		if (ctl.adv3) begin
			sum_s3 <= sum_c;
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < KSIZE; i++) begin
			sum_c = sum_c + CSUM_W'(prod_s2[i]);
		end
	end

	assign col  = col_q;
	assign csum = sum_s3;

endmodule

`default_nettype wire
